// File: rtl/lz4bd_pkg.sv
// Shared types and constants for the LZ4 block decompressor.
// No dependencies; used by every module of the block.
`timescale 1ns / 1ps

package lz4bd_pkg;

  // Command codes carried in the cmd field of an input transaction.
  localparam logic CMD_BYTE    = 1'b0;
  localparam logic CMD_ADVANCE = 1'b1;

  // Sticky error codes.
  localparam logic [1:0] ERR_NONE      = 2'd0;
  localparam logic [1:0] ERR_OFFSET    = 2'd1;
  localparam logic [1:0] ERR_TRUNCATED = 2'd2;
  localparam logic [1:0] ERR_COMMAND   = 2'd3;

  // The produced-byte count saturates here, whatever the window size.
  localparam int unsigned PRODUCED_W   = 17;
  localparam logic [PRODUCED_W-1:0] PRODUCED_MAX = 17'd65536;

  localparam logic [7:0] BYTE_ALL_ONES = 8'hFF;
  localparam logic [3:0] NIBBLE_EXT    = 4'hF;
  localparam logic [3:0] MIN_MATCH     = 4'd4;

  typedef struct packed {
    logic       cmd;
    logic [7:0] in_byte;
    logic       last_byte;
  } in_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       out_valid;
    logic       match_pending;
    logic       done_res;
    logic [1:0] error_code;
  } out_t;

  // Per-transaction control handed from the decoder to the history stage.
  typedef struct packed {
    logic [7:0] lit_byte;
    logic       copy;
    logic       wen;
    logic       match_pending;
    logic       done;
    logic [1:0] error;
  } step_t;

endpackage

// File: rtl/lz4_block_decompressor_top.sv
// Top level of the LZ4 block decompressor.
// Depends on lz4bd_pkg, lz4bd_ctrl and lz4bd_hist.
`timescale 1ns / 1ps

// Usage: the producer sends one input transaction per compressed source byte
// (cmd 0) and one per pending match byte (cmd 1) while the last result showed
// match_pending. Every input transaction yields exactly one result transaction
// carrying the decoded byte (if any), match_pending, done_res and error_code.
// A transaction moves on a rising edge where valid is high and stall is low.
//
// Pipeline: at the accepting edge the decoder updates its state and issues the
// window read into the read stage; the registered read data (or a forwarded
// byte) then moves into the output register when that register is empty or
// not stalled. Throughput is one transaction per cycle while the receiver does
// not stall, including back-to-back match copies at distance one; the history
// memory has a single read port and a single write port, and a copy that reads
// the byte written in the same cycle takes it from a forwarding register.
//
// Reset clears the decoder state and the valid flags of the read stage and of
// the output register; the history window is not cleared because it is only
// read at entries already written. When the receiver stalls, the result in the
// output register holds and one more input transaction is still taken into the
// read stage; only with both stages full does in_stall_o rise.

module lz4_block_decompressor_top #(
  parameter int WINDOW_BYTES = 65536,
  parameter int LENGTH_BITS  = 32
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_stall_o,
  input  lz4bd_pkg::in_t  in_data_i,
  output logic            out_valid_o,
  input  logic            out_stall_i,
  output lz4bd_pkg::out_t out_data_o
);

  localparam int AW = $clog2(WINDOW_BYTES);

  logic             accept;
  logic             hold;
  lz4bd_pkg::step_t step;
  logic [AW-1:0]    rd_addr;
  logic [AW-1:0]    wr_addr;

  assign accept     = in_valid_i && !hold;
  assign in_stall_o = hold;

  lz4bd_ctrl #(
    .WINDOW_BYTES(WINDOW_BYTES),
    .LENGTH_BITS (LENGTH_BITS)
  ) u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (accept),
    .in_data_i(in_data_i),
    .step_o   (step),
    .rd_addr_o(rd_addr),
    .wr_addr_o(wr_addr)
  );

  lz4bd_hist #(
    .WINDOW_BYTES(WINDOW_BYTES)
  ) u_hist (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .accept_i   (accept),
    .step_i     (step),
    .rd_addr_i  (rd_addr),
    .wr_addr_i  (wr_addr),
    .hold_o     (hold),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o)
  );

endmodule

// File: rtl/lz4bd_ctrl.sv
// Sequence decoder of the LZ4 block decompressor: token, lengths, offset.
// Depends on lz4bd_pkg.
`timescale 1ns / 1ps

module lz4bd_ctrl #(
  parameter int WINDOW_BYTES = 65536,
  parameter int LENGTH_BITS  = 32
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            accept_i,
  input  lz4bd_pkg::in_t                  in_data_i,
  output lz4bd_pkg::step_t                step_o,
  output logic [$clog2(WINDOW_BYTES)-1:0] rd_addr_o,
  output logic [$clog2(WINDOW_BYTES)-1:0] wr_addr_o
);

  localparam int AW    = $clog2(WINDOW_BYTES);
  localparam int IDX_W = AW + 2;
  localparam int PW    = lz4bd_pkg::PRODUCED_W;

  typedef enum logic [2:0] {
    PH_TOKEN, PH_LIT_EXT, PH_LIT, PH_OFF_LO, PH_OFF_HI, PH_MATCH_EXT, PH_MATCH
  } phase_e;

  phase_e                 phase_q, phase_d;
  logic [AW-1:0]          wp_q, wp_d;
  logic [PW-1:0]          prod_q, prod_d;
  logic [LENGTH_BITS-1:0] lit_q, lit_d;
  logic [LENGTH_BITS-1:0] ml_q, ml_d;
  logic [15:0]            dist_q, dist_d;
  logic [3:0]             nib_q, nib_d;
  logic                   fin_q, fin_d;
  logic [1:0]             err_q, err_d;

  logic [1:0]             fail_code;
  logic                   produce;
  logic                   copy;
  logic [7:0]             b;
  logic                   last;
  logic [15:0]            full_dist;
  logic                   bad_offset;
  logic [LENGTH_BITS:0]   lit_sum;
  logic [LENGTH_BITS:0]   ml_sum;
  logic [AW:0]            wp_inc;
  logic [IDX_W-1:0]       idx_raw;
  logic [IDX_W-1:0]       idx_wrap;

  assign b    = in_data_i.in_byte;
  assign last = in_data_i.last_byte;

  assign full_dist  = {b, dist_q[7:0]};
  assign bad_offset = (full_dist == 16'd0) || ({1'b0, full_dist} > prod_q) ||
                      ({1'b0, full_dist} > PW'(WINDOW_BYTES));

  // Saturating length adds; the match extension folds in the minimum match of
  // four on its closing byte, which gives the same saturated total.
  assign lit_sum = {1'b0, lit_q} + (LENGTH_BITS+1)'(b);
  assign ml_sum  = {1'b0, ml_q} + (LENGTH_BITS+1)'(b) +
                   (((b != lz4bd_pkg::BYTE_ALL_ONES) && !last)
                    ? (LENGTH_BITS+1)'(lz4bd_pkg::MIN_MATCH) : '0);

  assign wp_inc = {1'b0, wp_q} + (AW+1)'(1);

  // Copy source: write pointer minus distance, modulo the window.
  assign idx_raw  = IDX_W'(wp_q) + IDX_W'(WINDOW_BYTES) - IDX_W'(dist_q);
  assign idx_wrap = (idx_raw >= IDX_W'(WINDOW_BYTES)) ? idx_raw - IDX_W'(WINDOW_BYTES)
                                                      : idx_raw;
  assign rd_addr_o = idx_wrap[AW-1:0];
  assign wr_addr_o = wp_q;

  always_comb begin
    phase_d   = phase_q;
    wp_d      = wp_q;
    prod_d    = prod_q;
    lit_d     = lit_q;
    ml_d      = ml_q;
    dist_d    = dist_q;
    nib_d     = nib_q;
    fin_d     = fin_q;
    err_d     = err_q;
    fail_code = lz4bd_pkg::ERR_NONE;
    produce   = 1'b0;
    copy      = 1'b0;

    if (err_q == lz4bd_pkg::ERR_NONE && !fin_q) begin
      if (in_data_i.cmd == lz4bd_pkg::CMD_ADVANCE) begin
        if (phase_q != PH_MATCH) begin
          fail_code = lz4bd_pkg::ERR_COMMAND;
        end else begin
          produce = 1'b1;
          copy    = 1'b1;
          ml_d    = ml_q - LENGTH_BITS'(1);
          if (ml_q == LENGTH_BITS'(1)) phase_d = PH_TOKEN;
        end
      end else begin
        unique case (phase_q)
          PH_TOKEN: begin
            nib_d = b[3:0];
            if (b[7:4] == lz4bd_pkg::NIBBLE_EXT) begin
              lit_d   = LENGTH_BITS'(lz4bd_pkg::NIBBLE_EXT);
              phase_d = PH_LIT_EXT;
              if (last) fail_code = lz4bd_pkg::ERR_TRUNCATED;
            end else if (b[7:4] == 4'd0) begin
              if (last) fin_d = 1'b1;
              else phase_d = PH_OFF_LO;
            end else begin
              lit_d   = LENGTH_BITS'(b[7:4]);
              phase_d = PH_LIT;
              if (last) fail_code = lz4bd_pkg::ERR_TRUNCATED;
            end
          end
          PH_LIT_EXT: begin
            lit_d = lit_sum[LENGTH_BITS] ? '1 : lit_sum[LENGTH_BITS-1:0];
            if (b != lz4bd_pkg::BYTE_ALL_ONES) phase_d = PH_LIT;
            if (last) fail_code = lz4bd_pkg::ERR_TRUNCATED;
          end
          PH_LIT: begin
            produce = 1'b1;
            lit_d   = lit_q - LENGTH_BITS'(1);
            if (lit_q == LENGTH_BITS'(1)) begin
              if (last) fin_d = 1'b1;
              else phase_d = PH_OFF_LO;
            end else if (last) begin
              fail_code = lz4bd_pkg::ERR_TRUNCATED;
            end
          end
          PH_OFF_LO: begin
            dist_d = {8'd0, b};
            if (last) fail_code = lz4bd_pkg::ERR_TRUNCATED;
            else phase_d = PH_OFF_HI;
          end
          PH_OFF_HI: begin
            dist_d = full_dist;
            if (bad_offset) begin
              fail_code = lz4bd_pkg::ERR_OFFSET;
            end else if (last) begin
              fail_code = lz4bd_pkg::ERR_TRUNCATED;
            end else if (nib_q == lz4bd_pkg::NIBBLE_EXT) begin
              ml_d    = LENGTH_BITS'(lz4bd_pkg::NIBBLE_EXT);
              phase_d = PH_MATCH_EXT;
            end else begin
              ml_d    = LENGTH_BITS'(nib_q) + LENGTH_BITS'(lz4bd_pkg::MIN_MATCH);
              phase_d = PH_MATCH;
            end
          end
          PH_MATCH_EXT: begin
            ml_d = ml_sum[LENGTH_BITS] ? '1 : ml_sum[LENGTH_BITS-1:0];
            if (last) fail_code = lz4bd_pkg::ERR_TRUNCATED;
            else if (b != lz4bd_pkg::BYTE_ALL_ONES) phase_d = PH_MATCH;
          end
          default: begin
            // A compressed byte while match bytes are still owed.
            fail_code = lz4bd_pkg::ERR_COMMAND;
          end
        endcase
      end

      if (fail_code != lz4bd_pkg::ERR_NONE) begin
        err_d   = fail_code;
        phase_d = PH_TOKEN;
      end

      if (produce) begin
        wp_d = (wp_inc == (AW+1)'(WINDOW_BYTES)) ? '0 : wp_inc[AW-1:0];
        if (prod_q < lz4bd_pkg::PRODUCED_MAX) prod_d = prod_q + PW'(1);
      end
    end
  end

  always_comb begin
    step_o.lit_byte      = b;
    step_o.copy          = copy;
    step_o.wen           = produce;
    step_o.match_pending = (err_d == lz4bd_pkg::ERR_NONE) && !fin_d && (phase_d == PH_MATCH);
    step_o.done          = fin_d;
    step_o.error         = err_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_TOKEN;
      wp_q    <= '0;
      prod_q  <= '0;
      lit_q   <= '0;
      ml_q    <= '0;
      dist_q  <= '0;
      nib_q   <= '0;
      fin_q   <= 1'b0;
      err_q   <= lz4bd_pkg::ERR_NONE;
    end else if (accept_i) begin
      phase_q <= phase_d;
      wp_q    <= wp_d;
      prod_q  <= prod_d;
      lit_q   <= lit_d;
      ml_q    <= ml_d;
      dist_q  <= dist_d;
      nib_q   <= nib_d;
      fin_q   <= fin_d;
      err_q   <= err_d;
    end
  end

endmodule

// File: rtl/lz4bd_hist.sv
// History window memory, read-data stage with forwarding, and output register.
// Depends on lz4bd_pkg.
`timescale 1ns / 1ps

module lz4bd_hist #(
  parameter int WINDOW_BYTES = 65536
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            accept_i,
  input  lz4bd_pkg::step_t                step_i,
  input  logic [$clog2(WINDOW_BYTES)-1:0] rd_addr_i,
  input  logic [$clog2(WINDOW_BYTES)-1:0] wr_addr_i,
  output logic                            hold_o,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output lz4bd_pkg::out_t                 out_data_o
);

  localparam int AW = $clog2(WINDOW_BYTES);

  logic [7:0]       hist_mem [WINDOW_BYTES];

  logic             s1_valid_q;
  lz4bd_pkg::step_t s1_step_q;
  logic [AW-1:0]    s1_waddr_q;
  logic [7:0]       rdata_q;
  logic             fwd_hit_q;
  logic [7:0]       fwd_data_q;
  logic             out_valid_q;
  lz4bd_pkg::out_t  out_q;

  logic             s1_move;
  logic             s1_write;
  logic [7:0]       s1_byte;

  assign s1_move  = s1_valid_q && (!out_valid_q || !out_stall_i);
  assign s1_write = s1_move && s1_step_q.wen;
  assign s1_byte  = !s1_step_q.copy ? s1_step_q.lit_byte :
                    fwd_hit_q       ? fwd_data_q : rdata_q;
  assign hold_o   = s1_valid_q && out_valid_q && out_stall_i;

  // One read port, taken when a transaction enters; one write port, used when
  // the read-data stage retires a produced byte.
  always_ff @(posedge clk_i) begin
    if (accept_i) begin
      rdata_q    <= hist_mem[rd_addr_i];
      fwd_hit_q  <= s1_write && (s1_waddr_q == rd_addr_i);
      fwd_data_q <= s1_byte;
      s1_step_q  <= step_i;
      s1_waddr_q <= wr_addr_i;
    end
    if (s1_write) begin
      hist_mem[s1_waddr_q] <= s1_byte;
    end
    if (s1_move) begin
      out_q.out_byte      <= s1_step_q.wen ? s1_byte : 8'd0;
      out_q.out_valid     <= s1_step_q.wen;
      out_q.match_pending <= s1_step_q.match_pending;
      out_q.done_res      <= s1_step_q.done;
      out_q.error_code    <= s1_step_q.error;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (accept_i) s1_valid_q <= 1'b1;
      else if (s1_move) s1_valid_q <= 1'b0;
      if (s1_move) out_valid_q <= 1'b1;
      else if (!out_stall_i) out_valid_q <= 1'b0;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

// File: rtl/lz4bd_checker.sv
// Port-level checks for the LZ4 block decompressor, bound to its top level.
// Depends on lz4bd_pkg and lz4_block_decompressor_top.
`timescale 1ns / 1ps

module lz4bd_checker (
  input logic            clk_i,
  input logic            rst_ni,
  input logic            out_valid_i,
  input logic            out_stall_i,
  input lz4bd_pkg::out_t out_data_i
);

  logic       done_seen_q;
  logic [1:0] err_seen_q;
  logic       out_xfer;

  assign out_xfer = out_valid_i && !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_seen_q <= 1'b0;
      err_seen_q  <= lz4bd_pkg::ERR_NONE;
    end else if (out_xfer) begin
      if (out_data_i.done_res) done_seen_q <= 1'b1;
      if (err_seen_q == lz4bd_pkg::ERR_NONE) err_seen_q <= out_data_i.error_code;
    end
  end

  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_stall_i |=> out_valid_i && $stable(out_data_i))
    else $error("result changed while stalled");

  a_done_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && done_seen_q |-> out_data_i.done_res && !out_data_i.out_valid)
    else $error("done flag dropped or byte emitted after done");

  a_err_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (err_seen_q != lz4bd_pkg::ERR_NONE) |->
      out_data_i.error_code == err_seen_q)
    else $error("sticky error changed");

  // A literal that arrives with a premature last_byte is still emitted in the
  // same result that raises the error, so only the pending flag is checked.
  a_err_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (out_data_i.error_code != lz4bd_pkg::ERR_NONE) |->
      !out_data_i.match_pending)
    else $error("pending match reported with an error");

  a_byte_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_data_i.out_valid |-> out_data_i.out_byte == 8'd0)
    else $error("nonzero byte without a decoded byte");

endmodule

bind lz4_block_decompressor_top lz4bd_checker u_lz4bd_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .out_valid_i(out_valid_o),
  .out_stall_i(out_stall_i),
  .out_data_i (out_data_o)
);
